/* src/ssprx_pkg.sv */
package ssprx_pkg;

	localparam int unsigned SSPRX_MAX_PACKET_BYTES = 256;
	localparam logic [7:0]  SSPRX_TIMEOUT_RESET    = 8'd6;
	localparam logic [7:0]  SSPRX_SYNC_BYTE        = 8'hFF;
	localparam logic [8:0]  SSPRX_HEADER_BYTES     = 9'd4;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_BYTE  = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;
	localparam logic [1:0] ACT_LINE  = 2'd3;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_HEADER = 3'd1;
	localparam logic [2:0] ST_TOO_LARGE  = 3'd2;
	localparam logic [2:0] ST_CHECKSUM   = 3'd3;
	localparam logic [2:0] ST_TIMEOUT    = 3'd4;
	localparam logic [2:0] ST_LINE       = 3'd5;

	localparam logic KIND_PARAM  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] rx_byte;
		logic [8:0] capacity;
	} item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] param_index;
		logic [7:0] param_byte;
		logic [2:0] status;
		logic [7:0] packet_id;
		logic [7:0] error_byte;
		logic [8:0] packet_length;
	} result_t;

	typedef struct packed {
		logic       active;
		logic [8:0] byte_count;
		logic [8:0] total_size;
		logic [8:0] size_limit;
		logic [7:0] running_sum;
		logic [8:0] elapsed_ticks;
		logic [7:0] first_byte;
		logic [7:0] held_id;
		logic [7:0] held_error;
	} state_t;

endpackage

/* src/ssprx_if.sv */
interface ssprx_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] rx_byte;
	logic [8:0] capacity;

	modport source (output valid, output action, output rx_byte, output capacity, input ready);
	modport sink (input valid, input action, input rx_byte, input capacity, output ready);
endinterface

interface ssprx_result_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] param_index;
	logic [7:0] param_byte;
	logic [2:0] status;
	logic [7:0] packet_id;
	logic [7:0] error_byte;
	logic [8:0] packet_length;

	modport source (output valid, output kind, output param_index, output param_byte,
		output status, output packet_id, output error_byte, output packet_length,
		input ready);
	modport sink (input valid, input kind, input param_index, input param_byte,
		input status, input packet_id, input error_byte, input packet_length,
		output ready);
endinterface

/* src/ssprx_step.sv */
module ssprx_step #(
	parameter int unsigned MAX_PACKET_BYTES = ssprx_pkg::SSPRX_MAX_PACKET_BYTES
) (
	input  ssprx_pkg::state_t  st,
	input  ssprx_pkg::item_t   it,
	input  logic [7:0]         timeout_ticks,
	output ssprx_pkg::state_t  nxt,
	output logic               emit,
	output ssprx_pkg::result_t res
);

	localparam logic [8:0] MaxBytes = 9'(MAX_PACKET_BYTES);

	always_comb begin
		logic [8:0] idx;
		logic [8:0] ticks;
		logic [8:0] size;
		logic       done;

		nxt = st;
		emit = 1'b0;
		done = 1'b0;
		idx = st.byte_count;
		ticks = st.elapsed_ticks + 9'd1;
		size = ssprx_pkg::SSPRX_HEADER_BYTES + {1'b0, it.rx_byte};
		res.kind = ssprx_pkg::KIND_STATUS;
		res.param_index = '0;
		res.param_byte = '0;
		res.status = ssprx_pkg::ST_OK;

		case (it.action)
			ssprx_pkg::ACT_START: begin
				nxt = '0;
				nxt.active = 1'b1;
				nxt.size_limit = (it.capacity > MaxBytes) ? MaxBytes : it.capacity;
			end
			ssprx_pkg::ACT_LINE: begin
				if (st.active) begin
					nxt.active = 1'b0;
					emit = 1'b1;
					res.status = ssprx_pkg::ST_LINE;
				end
			end
			ssprx_pkg::ACT_TICK: begin
				if (st.active) begin
					nxt.elapsed_ticks = ticks;
					if (ticks > {1'b0, timeout_ticks}) begin
						nxt.active = 1'b0;
						emit = 1'b1;
						res.status = ssprx_pkg::ST_TIMEOUT;
					end
				end
			end
			ssprx_pkg::ACT_BYTE: begin
				if (st.active) begin
					nxt.byte_count = idx + 9'd1;
					if (idx == 9'd0) begin
						nxt.first_byte = it.rx_byte;
					end else if (idx == 9'd1) begin
						nxt.first_byte = st.first_byte & it.rx_byte;
					end else if (idx == 9'd2) begin
						nxt.held_id = it.rx_byte;
						nxt.running_sum = it.rx_byte;
					end else begin
						if (idx == 9'd3) begin
							if (st.first_byte != ssprx_pkg::SSPRX_SYNC_BYTE) begin
								done = 1'b1;
								nxt.active = 1'b0;
								emit = 1'b1;
								res.status = ssprx_pkg::ST_BAD_HEADER;
							end else begin
								nxt.total_size = size;
								if (size > st.size_limit) begin
									done = 1'b1;
									nxt.active = 1'b0;
									emit = 1'b1;
									res.status = ssprx_pkg::ST_TOO_LARGE;
								end
							end
						end
						if (!done) begin
							if ((idx + 9'd1) == nxt.total_size) begin
								nxt.active = 1'b0;
								emit = 1'b1;
								res.status = (it.rx_byte == ~st.running_sum) ?
									ssprx_pkg::ST_OK : ssprx_pkg::ST_CHECKSUM;
							end else begin
								nxt.running_sum = st.running_sum + it.rx_byte;
								if (idx == 9'd4) begin
									nxt.held_error = it.rx_byte;
								end else if (idx >= 9'd5) begin
									emit = 1'b1;
									res.kind = ssprx_pkg::KIND_PARAM;
									res.param_index = 8'(idx - 9'd5);
									res.param_byte = it.rx_byte;
								end
							end
						end
					end
				end
			end
			default: begin
				nxt = st;
			end
		endcase

		res.packet_id = nxt.held_id;
		res.error_byte = nxt.held_error;
		res.packet_length = nxt.total_size;
	end

endmodule

/* src/servo_status_packet_receiver_core.sv */
// Status packet receiver. A start transaction arms reception and sets the size limit; byte
// transactions then carry the packet, tick transactions count time and a line error aborts it.
// Parameter bytes (index five up to the byte before the checksum) come out as they arrive, and
// every armed reception that is not cut short by a new start ends with one status transaction
// that carries the device id, the error byte and the packet length. The block takes one input
// transaction per clock cycle while input is not stalled; each one passes through an input
// register and the packet state logic into the result register, from which it can be taken.
// The result register holds a result until it is taken, and input is stalled only while both
// registers are full and the held result is not being taken.
module servo_status_packet_receiver_core #(
	parameter int unsigned MAX_PACKET_BYTES = ssprx_pkg::SSPRX_MAX_PACKET_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	ssprx_item_if.sink     item,
	ssprx_result_if.source result
);

	logic               valid_s1;
	ssprx_pkg::item_t   item_s1;
	ssprx_pkg::state_t  state_q;
	ssprx_pkg::state_t  state_next;
	logic [7:0]         timeout_q;
	logic               out_valid_q;
	ssprx_pkg::result_t result_q;
	ssprx_pkg::result_t step_res;
	logic               step_emit;
	logic               advance;

	assign advance = !out_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= ssprx_pkg::SSPRX_TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.action <= item.action;
			item_s1.rx_byte <= item.rx_byte;
			item_s1.capacity <= item.capacity;
		end
	end

	ssprx_step #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_step (
		.st(state_q),
		.it(item_s1),
		.timeout_ticks(timeout_q),
		.nxt(state_next),
		.emit(step_emit),
		.res(step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && step_emit;
			if (valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && step_emit) begin
			result_q <= step_res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.kind = result_q.kind;
	assign result.param_index = result_q.param_index;
	assign result.param_byte = result_q.param_byte;
	assign result.status = result_q.status;
	assign result.packet_id = result_q.packet_id;
	assign result.error_byte = result_q.error_byte;
	assign result.packet_length = result_q.packet_length;

endmodule
